FILE: hdl/str_pkg.sv
// ----------------------------------------------------------------------------
// str_pkg
// Types and constants shared by the trapezoidal stepper ramp.
// ----------------------------------------------------------------------------
package str_pkg;

  typedef struct packed {
    logic               operation;
    logic               relative_mode;
    logic signed [31:0] target;
  } str_in_t;

  typedef struct packed {
    logic [15:0]        reload_value;
    logic               step_toggle;
    logic [1:0]         motion_state;
    logic signed [31:0] position;
    logic               stop_event;
    logic               move_started;
  } str_out_t;

  localparam logic [1:0] ST_STOP  = 2'd0;
  localparam logic [1:0] ST_ACCEL = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DECEL = 2'd3;

  localparam logic [2:0] REG_ACCEL = 3'd0;
  localparam logic [2:0] REG_DECEL = 3'd1;
  localparam logic [2:0] REG_FIRST = 3'd2;
  localparam logic [2:0] REG_MIND  = 3'd3;
  localparam logic [2:0] REG_MAXS  = 3'd4;

  localparam logic [31:0] SINGLE_STEP_DELAY = 32'd1000;
  localparam logic [32:0] DECEL_MAG_MAX     = 33'h1_0000_0000 >> 1;

endpackage

FILE: hdl/stepper_trapezoid_ramp.sv
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp
// Trapezoidal speed ramp for one stepper motor with iterative divider.
// ----------------------------------------------------------------------------
// Flow: skip ticks, zero and single-step moves go straight to the result;
//   stop/run ticks pass through S_TICK; ramp ticks run one signed division;
//   moves run a shift-add multiply and a division, plus a second division when the capped ramp needs its own.
// Handshake: one item at a time; in_ready low from accept until the result
//   beat is taken.
// Reset (rst_n low, synchronous): state, configuration and ramp registers to defaults, motor stopped.
module stepper_trapezoid_ramp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  str_pkg::str_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output str_pkg::str_out_t   out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import str_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_PLAN, S_MUL, S_LIMDIV, S_LIM, S_MAGDIV, S_MAG,
    S_DIV, S_RECUR, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [15:0] accel_r, decel_r, first_r, mind_r;
  logic [23:0] maxs_r;

  // ramp state
  logic        phase_r, dir_r;
  logic [1:0]  run_r;
  logic [31:0] cnt_r, idx_r, dly_r, rem_r, last_r, dbeg_r, dsteps_r, pos_r;

  // item
  logic        op_r, stopev_r, started_r;
  logic [32:0] n_r;          // distance minus one
  logic [32:0] lim_r;

  // shared shift-add multiplier / restoring divider
  // dividend magnitude up to 49 bits, divisor up to 35 bits
  logic [48:0] quo_r;        // dividend shifting into quotient
  logic [49:0] part_r;       // partial remainder
  logic [34:0] dvs_r;
  logic [5:0]  cnt6_r;
  logic        qneg_r, rneg_r;
  logic [48:0] prod_r;
  logic [15:0] mplr_r;

  logic [49:0] trial;
  logic [49:0] shifted;
  assign shifted = {part_r[48:0], quo_r[48]};
  assign trial   = shifted - {15'd0, dvs_r};

  logic signed [33:0] num_s, den_s;
  always_comb begin
    num_s = {{2{dly_r[31]}}, dly_r} + {{2{dly_r[31]}}, dly_r}
          + {{2{rem_r[31]}}, rem_r};
    den_s = {idx_r[31], idx_r, 1'b0} + {idx_r[31], idx_r, 1'b0} + 34'sd1;
  end

  logic [32:0] sum16;
  assign sum16 = {17'd0, accel_r} + {17'd0, decel_r};

  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    out_data.reload_value = dly_r[15:0];
    out_data.step_toggle  = !op_r;
    out_data.motion_state = run_r;
    out_data.position     = pos_r;
    out_data.stop_event   = stopev_r;
    out_data.move_started = started_r;
  end

  // planning helpers
  logic signed [32:0] diff;
  logic [32:0] span;
  logic        pdir;
  always_comb begin
    if (in_data.relative_mode) begin
      diff = {in_data.target[31], in_data.target};
      pdir = !in_data.target[31];
    end else begin
      diff = {in_data.target[31], in_data.target} - {pos_r[31], pos_r};
      pdir = !($signed(pos_r) > in_data.target);
    end
    span = diff[32] ? -diff : diff;
  end

  logic [32:0] mag_sat;
  always_comb begin
    mag_sat = (quo_r[48:33] != 16'd0) ? DECEL_MAG_MAX : quo_r[32:0];
    if (mag_sat == 33'd0) mag_sat = 33'd1;
    if (mag_sat > DECEL_MAG_MAX) mag_sat = DECEL_MAG_MAX;
  end

  logic [32:0] lim1;
  assign lim1 = (quo_r[48:33] != 16'd0) ? 33'h1_FFFF_FFFF
              : ((quo_r[32:0] == 33'd0) ? 33'd1 : quo_r[32:0]);

  logic [23:0] maxs1;
  assign maxs1 = (maxs_r == 24'd0) ? 24'd1 : maxs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      accel_r <= 16'd100; decel_r <= 16'd100; first_r <= 16'd10000;
      mind_r <= 16'd1000; maxs_r <= 24'd100;
      phase_r <= 1'b0; dir_r <= 1'b0; run_r <= ST_STOP;
      cnt_r <= '0; idx_r <= '0; dly_r <= '0; rem_r <= '0; last_r <= '0;
      dbeg_r <= '0; dsteps_r <= '0; pos_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            case (cfg_index)
              REG_ACCEL: accel_r <= cfg_data[15:0];
              REG_DECEL: decel_r <= cfg_data[15:0];
              REG_FIRST: first_r <= cfg_data[15:0];
              REG_MIND:  mind_r  <= cfg_data[15:0];
              REG_MAXS:  maxs_r  <= cfg_data[23:0];
              default: ;
            endcase
          end else if (in_valid) begin
            op_r <= in_data.operation;
            stopev_r <= 1'b0;
            started_r <= in_data.operation && (span != 33'd0);
            if (in_data.operation) begin
              if (span != 33'd0) begin
                dir_r <= pdir;
                n_r <= span - 33'd1;
                if (span == 33'd1) begin
                  idx_r <= 32'hFFFF_FFFF;
                  run_r <= ST_DECEL;
                  dly_r <= SINGLE_STEP_DELAY;
                  pos_r <= pdir ? pos_r - 32'd1 : pos_r + 32'd1;
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_PLAN;
                end
              end else begin
                state_r <= S_OUT;
              end
            end else begin
              phase_r <= !phase_r;
              state_r <= phase_r ? S_TICK : S_OUT;
            end
          end
        end
        S_TICK: begin
          case (run_r)
            ST_STOP: begin
              cnt_r <= '0; rem_r <= '0; stopev_r <= 1'b1;
              state_r <= S_OUT;
            end
            ST_RUN: begin
              pos_r <= dir_r ? pos_r + 32'd1 : pos_r - 32'd1;
              cnt_r <= cnt_r + 32'd1;
              if (cnt_r + 32'd1 >= dbeg_r) begin
                idx_r <= dsteps_r; dly_r <= last_r; run_r <= ST_DECEL;
              end else begin
                dly_r <= {16'd0, mind_r};
              end
              state_r <= S_OUT;
            end
            default: begin
              pos_r <= dir_r ? pos_r + 32'd1 : pos_r - 32'd1;
              cnt_r <= cnt_r + 32'd1;
              idx_r <= idx_r + 32'd1;
              state_r <= S_DIV;
            end
          endcase
        end
        S_DIV: begin
          // load signed division (2d+rest)/(4n+1)
          quo_r  <= {15'd0, num_s[33] ? -num_s : num_s};
          part_r <= '0;
          dvs_r  <= {1'b0, den_s[33] ? -den_s : den_s};
          qneg_r <= num_s[33] ^ den_s[33];
          rneg_r <= num_s[33];
          cnt6_r <= 6'd49;
          state_r <= S_RECUR;
        end
        S_RECUR, S_LIMDIV, S_MAGDIV: begin
          if (cnt6_r != 6'd0) begin
            cnt6_r <= cnt6_r - 6'd1;
            if (!trial[49]) begin
              part_r <= trial; quo_r <= {quo_r[47:0], 1'b1};
            end else begin
              part_r <= shifted; quo_r <= {quo_r[47:0], 1'b0};
            end
          end else if (state_r == S_RECUR) begin
            logic [31:0] q32, r32, nd;
            q32 = qneg_r ? -quo_r[31:0] : quo_r[31:0];
            r32 = rneg_r ? -part_r[31:0] : part_r[31:0];
            nd  = dly_r - q32;
            if (run_r == ST_ACCEL) begin
              if (cnt_r >= dbeg_r) begin
                dly_r <= nd; rem_r <= r32;
                idx_r <= dsteps_r; run_r <= ST_DECEL;
              end else if ($signed(nd) <= $signed({16'd0, mind_r})) begin
                last_r <= nd; dly_r <= {16'd0, mind_r};
                rem_r <= '0; run_r <= ST_RUN;
              end else begin
                dly_r <= nd; rem_r <= r32;
              end
            end else begin
              dly_r <= nd; rem_r <= r32;
              if (!idx_r[31]) begin
                pos_r <= dir_r ? pos_r + 32'd1 : pos_r - 32'd1;
                run_r <= ST_STOP;
              end
            end
            state_r <= S_OUT;
          end else if (state_r == S_LIMDIV) begin
            lim_r <= lim1;
            state_r <= S_LIM;
          end else begin
            dsteps_r <= -mag_sat[31:0];
            dbeg_r <= n_r[31:0] - mag_sat[31:0];
            state_r <= S_MAG;
          end
        end
        S_PLAN: begin
          prod_r <= '0;
          quo_r  <= {16'd0, n_r};
          mplr_r <= decel_r;
          cnt6_r <= 6'd16;
          state_r <= S_MUL;
        end
        S_MUL: begin
          // shift-add multiply n * decel_rate
          if (cnt6_r != 6'd0) begin
            cnt6_r <= cnt6_r - 6'd1;
            if (mplr_r[0]) prod_r <= prod_r + quo_r;
            quo_r <= {quo_r[47:0], 1'b0};
            mplr_r <= {1'b0, mplr_r[15:1]};
          end else if (sum16 == 33'd0) begin
            // both rates zero: limit floors at one step
            lim_r <= 33'd1;
            state_r <= S_LIM;
          end else begin
            quo_r <= prod_r; part_r <= '0;
            dvs_r <= {2'd0, sum16};
            cnt6_r <= 6'd49;
            state_r <= S_LIMDIV;
          end
        end
        S_LIM: begin
          if (lim_r <= {9'd0, maxs1}) begin
            logic [32:0] m;
            m = n_r - lim_r;
            if (m == 33'd0) m = 33'd1;
            if (m > DECEL_MAG_MAX) m = DECEL_MAG_MAX;
            dsteps_r <= -m[31:0];
            dbeg_r <= n_r[31:0] - m[31:0];
            state_r <= S_MAG;
          end else if (decel_r == 16'd0) begin
            dsteps_r <= 32'h8000_0000;
            dbeg_r <= n_r[31:0] - 32'h8000_0000;
            state_r <= S_MAG;
          end else begin
            quo_r <= {25'd0, maxs1} * {33'd0, accel_r};
            part_r <= '0;
            dvs_r <= {19'd0, decel_r};
            cnt6_r <= 6'd49;
            state_r <= S_MAGDIV;
          end
        end
        S_MAG: begin
          if ({16'd0, first_r} <= {16'd0, mind_r}) begin
            dly_r <= {16'd0, mind_r}; run_r <= ST_RUN;
          end else begin
            dly_r <= {16'd0, first_r}; run_r <= ST_ACCEL;
          end
          idx_r <= '0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
